>>> src/btha_pkg.sv
package btha_pkg;

   // Table geometry.
   localparam int BLOCK_BYTES  = 4096;
   localparam int TABLE_BLOCKS = 1024;

   localparam int BLK_SHIFT = $clog2(BLOCK_BYTES);
   localparam int IDX_W     = $clog2(TABLE_BLOCKS);
   localparam int CNT_W     = $clog2(TABLE_BLOCKS + 1);
   localparam int NEED_W    = 33 - BLK_SHIFT;
   localparam int BLKIDX_W  = 32 - BLK_SHIFT;

   // Configuration registers.
   localparam int CSR_COUNT_W = 11;
   localparam logic [CSR_COUNT_W-1:0] BLOCKS_IN_USE_RESET = 11'd1024;
   localparam logic CSR_HEAP_BASE     = 1'b0;
   localparam logic CSR_BLOCKS_IN_USE = 1'b1;

   // Table entry layout.
   localparam int ENT_W = 3;
   typedef logic [ENT_W-1:0] entry_type;
   localparam entry_type ENT_TAKEN = 3'b001;
   localparam entry_type ENT_FIRST = 3'b010;
   localparam entry_type ENT_NEXT  = 3'b100;
   localparam logic [7:0] TYPE_MASK = 8'h0f;

   // Request opcodes.
   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   // Response status codes.
   typedef logic [1:0] status_type;
   localparam status_type ST_DONE    = 2'd0;
   localparam status_type ST_NOROOM  = 2'd1;
   localparam status_type ST_INVALID = 2'd2;

endpackage

>>> src/block_table_heap_allocator.sv
// Channel    Ports                                          Direction  Handshake
// request    req_opcode, req_request_bytes, req_free_address in         start high, busy low
// response   rsp_result_address, rsp_status                  out        rsp_strobe, one cycle
// csr        csr_index, csr_data                             in         csr_we
//
// After reset a clearing pass writes every table entry to free while busy is high.
// Configuration writes are taken during it.
// An allocate scans entries for a free run and then marks its blocks; a free walks the
// chain of entries. Invalid requests are answered from the check state without a table access.
// The table memory has one write port and one registered read port, one entry per cycle.
// The response beat shows for one cycle and cannot be held off; a new request may start then.
module block_table_heap_allocator (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic                   req_opcode,
   input  logic [31:0]            req_request_bytes,
   input  logic [31:0]            req_free_address,
   output logic                   rsp_strobe,
   output logic [31:0]            rsp_result_address,
   output btha_pkg::status_type   rsp_status,
   input  logic                   csr_we,
   input  logic                   csr_index,
   input  logic [31:0]            csr_data
);
   import btha_pkg::*;

   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_CHECK = 3'd2;
   localparam logic [2:0] S_SCAN  = 3'd3;
   localparam logic [2:0] S_MARK  = 3'd4;
   localparam logic [2:0] S_FREE  = 3'd5;

   logic [2:0]             state_ff, state_in;
   logic [31:0]            heap_base_ff, heap_base_in;
   logic [CSR_COUNT_W-1:0] blocks_in_use_ff, blocks_in_use_in;

   logic                   op_ff, op_in;
   logic [NEED_W-1:0]      need_ff, need_in;
   logic [BLKIDX_W-1:0]    blk_ff, blk_in;
   logic [CNT_W-1:0]       n_ff, n_in;
   logic [CNT_W-1:0]       issue_ff, issue_in;
   logic                   pend_valid_ff, pend_valid_in;
   logic [IDX_W-1:0]       pend_idx_ff, pend_idx_in;
   logic [CNT_W-1:0]       run_ff, run_in;
   logic [IDX_W-1:0]       start_ff, start_in;
   logic [CNT_W-1:0]       mark_ff, mark_in;
   logic                   strobe_ff, strobe_in;
   logic [31:0]            addr_ff, addr_in;
   status_type             status_ff, status_in;

   logic                   rd_en;
   entry_type              rd_data_ff;
   logic                   wr_en;
   logic [IDX_W-1:0]       wr_addr;
   entry_type              wr_data;
   entry_type              table_mem [TABLE_BLOCKS];

   logic [32:0]            need_sum;
   logic [31:0]            offset;
   logic [CNT_W-1:0]       managed;
   logic                   pend_last;
   logic                   taken;

   assign busy               = (state_ff != S_IDLE);
   assign rsp_strobe         = strobe_ff;
   assign rsp_result_address = addr_ff;
   assign rsp_status         = status_ff;

   // Request decode: block count, block index and managed entry count.
   assign need_sum = {1'b0, req_request_bytes} + 33'(BLOCK_BYTES - 1);
   assign offset   = req_free_address - heap_base_ff;
   assign managed  = (32'(blocks_in_use_ff) > 32'(TABLE_BLOCKS)) ?
                     CNT_W'(TABLE_BLOCKS) : CNT_W'(blocks_in_use_ff);

   // Table read pipeline: one read issued per cycle, evaluated the next cycle.
   assign rd_en     = ((state_ff == S_SCAN) || (state_ff == S_FREE)) &&
                      (32'(issue_ff) < 32'(n_ff));
   assign pend_last = ((32'(pend_idx_ff) + 32'd1) == 32'(n_ff));
   assign taken     = ((8'(rd_data_ff) & TYPE_MASK & 8'(ENT_TAKEN)) != 8'd0);

   // Configuration registers.
   always_comb begin
      heap_base_in     = heap_base_ff;
      blocks_in_use_in = blocks_in_use_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_HEAP_BASE:     heap_base_in = csr_data;
            CSR_BLOCKS_IN_USE: blocks_in_use_in = csr_data[CSR_COUNT_W-1:0];
            default:           heap_base_in = heap_base_ff;
         endcase
      end
   end

   // Sequencer.
   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      need_in       = need_ff;
      blk_in        = blk_ff;
      n_in          = n_ff;
      issue_in      = issue_ff;
      pend_valid_in = rd_en;
      pend_idx_in   = issue_ff[IDX_W-1:0];
      run_in        = run_ff;
      start_in      = start_ff;
      mark_in       = mark_ff;
      strobe_in     = 1'b0;
      addr_in       = addr_ff;
      status_in     = status_ff;
      wr_en         = 1'b0;
      wr_addr       = issue_ff[IDX_W-1:0];
      wr_data       = '0;

      if (rd_en) begin
         issue_in = issue_ff + CNT_W'(1);
      end

      case (state_ff)
         S_CLEAR: begin
            wr_en    = 1'b1;
            issue_in = issue_ff + CNT_W'(1);
            if (issue_ff[IDX_W-1:0] == IDX_W'(TABLE_BLOCKS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               op_in    = req_opcode;
               need_in  = need_sum[32:BLK_SHIFT];
               blk_in   = offset[31:BLK_SHIFT];
               n_in     = managed;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            pend_valid_in = 1'b0;
            run_in        = '0;
            addr_in       = '0;
            if (op_ff == OP_ALLOC) begin
               issue_in = '0;
               if (need_ff == '0) begin
                  strobe_in = 1'b1;
                  status_in = ST_INVALID;
                  state_in  = S_IDLE;
               end else if (n_ff == '0) begin
                  strobe_in = 1'b1;
                  status_in = ST_NOROOM;
                  state_in  = S_IDLE;
               end else if (32'(need_ff) > 32'(n_ff)) begin
                  strobe_in = 1'b1;
                  status_in = ST_INVALID;
                  state_in  = S_IDLE;
               end else begin
                  state_in = S_SCAN;
               end
            end else begin
               issue_in = CNT_W'(blk_ff);
               if (32'(blk_ff) >= 32'(n_ff)) begin
                  strobe_in = 1'b1;
                  status_in = ST_INVALID;
                  state_in  = S_IDLE;
               end else begin
                  state_in = S_FREE;
               end
            end
         end
         S_SCAN: begin
            // First-fit: count consecutive free entries until the run is long enough or the last managed entry is read.
            if (pend_valid_ff) begin
               if (taken) begin
                  run_in = '0;
               end else begin
                  if (run_ff == '0) begin
                     start_in = pend_idx_ff;
                  end
                  run_in = run_ff + CNT_W'(1);
               end
               if (!taken && ((32'(run_ff) + 32'd1) == 32'(need_ff))) begin
                  mark_in  = '0;
                  state_in = S_MARK;
               end else if (pend_last) begin
                  strobe_in = 1'b1;
                  status_in = ST_NOROOM;
                  addr_in   = '0;
                  state_in  = S_IDLE;
               end
            end
         end
         S_MARK: begin
            // Write the run: first flag on the head, has-next on all but the tail.
            wr_en   = 1'b1;
            wr_addr = start_ff + mark_ff[IDX_W-1:0];
            wr_data = ENT_TAKEN;
            if (mark_ff == '0) begin
               wr_data = wr_data | ENT_FIRST;
            end
            if ((32'(mark_ff) + 32'd1) < 32'(need_ff)) begin
               wr_data = wr_data | ENT_NEXT;
            end
            mark_in = mark_ff + CNT_W'(1);
            if ((32'(mark_ff) + 32'd1) == 32'(need_ff)) begin
               strobe_in = 1'b1;
               status_in = ST_DONE;
               addr_in   = heap_base_ff + (32'(start_ff) << BLK_SHIFT);
               state_in  = S_IDLE;
            end
         end
         S_FREE: begin
            // Clear the chain until an entry without has-next or the last managed entry.
            if (pend_valid_ff) begin
               wr_en   = 1'b1;
               wr_addr = pend_idx_ff;
               wr_data = '0;
               if (((rd_data_ff & ENT_NEXT) == '0) || pend_last) begin
                  strobe_in = 1'b1;
                  status_in = ST_DONE;
                  addr_in   = '0;
                  state_in  = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= S_CLEAR;
         issue_ff         <= '0;
         pend_valid_ff    <= 1'b0;
         strobe_ff        <= 1'b0;
         heap_base_ff     <= '0;
         blocks_in_use_ff <= BLOCKS_IN_USE_RESET;
      end else begin
         state_ff         <= state_in;
         issue_ff         <= issue_in;
         pend_valid_ff    <= pend_valid_in;
         strobe_ff        <= strobe_in;
         heap_base_ff     <= heap_base_in;
         blocks_in_use_ff <= blocks_in_use_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      need_ff     <= need_in;
      blk_ff      <= blk_in;
      n_ff        <= n_in;
      pend_idx_ff <= pend_idx_in;
      run_ff      <= run_in;
      start_ff    <= start_in;
      mark_ff     <= mark_in;
      addr_ff     <= addr_in;
      status_ff   <= status_in;
   end

   // Block table memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         table_mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= table_mem[issue_ff[IDX_W-1:0]];
      end
   end

endmodule

>>> src/btha_checker.sv
module btha_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 start,
   input logic                 busy,
   input logic                 rsp_strobe,
   input logic [31:0]          rsp_result_address,
   input btha_pkg::status_type rsp_status
);
   import btha_pkg::*;

   // An accepted request keeps the block busy on the next cycle.
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("request accepted but block not busy");

   // A response beat lasts exactly one cycle.
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("response strobe held longer than one cycle");

   // The response beat is shown only once the block is ready again.
   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("response shown while block busy");

   // A failed request returns a zero address.
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_status != ST_DONE)) |-> (rsp_result_address == 32'd0))
      else $error("failed request returned a nonzero address");

endmodule

bind block_table_heap_allocator btha_checker u_btha_checker (.*);

>>> bench/btha_reply_checker.sv
// Watches the request, reply and register channels of the heap allocator, keeps a
// private copy of the block table and register values, and checks each reply beat
// against the reply predicted when its request beat was accepted.
module btha_reply_checker (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic                  busy,
   input  logic                  req_opcode,
   input  logic [31:0]           req_request_bytes,
   input  logic [31:0]           req_free_address,
   input  logic                  rsp_strobe,
   input  logic [31:0]           rsp_result_address,
   input  btha_pkg::status_type  rsp_status,
   input  logic                  csr_we,
   input  logic                  csr_index,
   input  logic [31:0]           csr_data,
   output int                    mismatches,
   output int                    pending
);
   import btha_pkg::*;

   typedef struct packed {
      logic [31:0] address;
      status_type  status;
   } heap_reply_type;

   // Shadow copy of the allocator state.
   entry_type               heap_map [TABLE_BLOCKS];
   logic [31:0]             base_q;
   logic [CSR_COUNT_W-1:0]  blocks_q;
   heap_reply_type          replies_due [$];

   // Entries beyond the table size are never managed.
   function automatic int unsigned managed_blocks();
      return (blocks_q > TABLE_BLOCKS) ? TABLE_BLOCKS : blocks_q;
   endfunction

   // First-fit search; marks the run and yields its address when one is found.
   function automatic void predict_alloc(input logic [31:0] bytes,
                                         output logic [31:0] addr,
                                         output status_type st);
      int unsigned       n;
      int unsigned       run;
      int unsigned       first;
      int unsigned       i;
      longint unsigned   need;
      logic              found;
      entry_type         ent;
      n     = managed_blocks();
      need  = (64'(bytes) + 64'(BLOCK_BYTES - 1)) / 64'(BLOCK_BYTES);
      addr  = '0;
      run   = 0;
      first = 0;
      found = 1'b0;
      if (bytes == 0) begin
         st = ST_INVALID;
      end else if (n == 0) begin
         st = ST_NOROOM;
      end else if (need > n) begin
         st = ST_INVALID;
      end else begin
         for (i = 0; i < n && !found; i++) begin
            if ((heap_map[i] & ENT_TAKEN) != '0) begin
               run = 0;
            end else begin
               if (run == 0)
                  first = i;
               run++;
               if (run == need)
                  found = 1'b1;
            end
         end
         if (!found) begin
            st = ST_NOROOM;
         end else begin
            // Head carries the first flag; all but the tail carry has-next.
            for (i = 0; i < need; i++) begin
               ent = ENT_TAKEN;
               if (i == 0)
                  ent = ent | ENT_FIRST;
               if (i + 1 < need)
                  ent = ent | ENT_NEXT;
               heap_map[first + i] = ent;
            end
            addr = base_q + first * BLOCK_BYTES;
            st   = ST_DONE;
         end
      end
   endfunction

   // Clears from the addressed block through the first entry without has-next.
   function automatic status_type predict_free(input logic [31:0] address);
      int unsigned  n;
      int unsigned  i;
      logic [31:0]  blk;
      logic         stop;
      entry_type    ent;
      n    = managed_blocks();
      blk  = (address - base_q) >> BLK_SHIFT;
      stop = 1'b0;
      if (blk >= n)
         return ST_INVALID;
      for (i = blk; i < n && !stop; i++) begin
         ent         = heap_map[i];
         heap_map[i] = '0;
         if ((ent & ENT_NEXT) == '0)
            stop = 1'b1;
      end
      return ST_DONE;
   endfunction

   // Register writes, request beats and reply beats, all sampled at the clock edge.
   always @(posedge clock) begin : watch
      heap_reply_type  want;
      heap_reply_type  got;
      logic [31:0]     w_addr;
      status_type      w_st;
      int              k;
      if (reset) begin
         base_q   = '0;
         blocks_q = BLOCKS_IN_USE_RESET;
         for (k = 0; k < TABLE_BLOCKS; k++)
            heap_map[k] = '0;
         replies_due.delete();
         mismatches <= 0;
      end else begin
         if (csr_we) begin
            if (csr_index == CSR_HEAP_BASE)
               base_q = csr_data;
            else
               blocks_q = csr_data[CSR_COUNT_W-1:0];
         end

         if (start && !busy) begin
            w_addr = '0;
            if (req_opcode == OP_ALLOC)
               predict_alloc(req_request_bytes, w_addr, w_st);
            else
               w_st = predict_free(req_free_address);
            want.address = w_addr;
            want.status  = w_st;
            replies_due.push_back(want);
         end

         if (rsp_strobe) begin
            got.address = rsp_result_address;
            got.status  = rsp_status;
            if (replies_due.size() == 0) begin
               if (mismatches < 10)
                  $display("%0t: reply beat with nothing owed: address %h status %0d",
                           $realtime, got.address, got.status);
               mismatches <= mismatches + 1;
            end else begin
               want = replies_due.pop_front();
               if (got.address !== want.address || got.status !== want.status) begin
                  if (mismatches < 10)
                     $display("%0t: mismatch: expected %h status %0d, got %h status %0d",
                              $realtime, want.address, want.status, got.address, got.status);
                  mismatches <= mismatches + 1;
               end
            end
         end
      end
      pending <= replies_due.size();
   end

endmodule

>>> bench/block_table_heap_allocator_tb.sv
// Drives request beats and register writes into the heap allocator; the checker
// beside the block predicts and compares every reply beat.
module block_table_heap_allocator_tb;
   import btha_pkg::*;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         start = 1'b0;
   logic         busy;
   logic         req_opcode = OP_ALLOC;
   logic [31:0]  req_request_bytes = '0;
   logic [31:0]  req_free_address = '0;
   logic         rsp_strobe;
   logic [31:0]  rsp_result_address;
   status_type   rsp_status;
   logic         csr_we = 1'b0;
   logic         csr_index = CSR_HEAP_BASE;
   logic [31:0]  csr_data = '0;

   int           mismatches;
   int           pending;

   // Heap setting currently programmed, and addresses handed out and not yet freed.
   logic [31:0]  cur_base;
   int           cur_count;
   logic [31:0]  live_addrs [$];
   logic         issued_ops [$];

   int           allocs_sent = 0;
   int           frees_sent = 0;
   int           settings = 0;
   int           replies_done = 0;
   int           replies_noroom = 0;
   int           replies_invalid = 0;

   block_table_heap_allocator dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_opcode         (req_opcode),
      .req_request_bytes  (req_request_bytes),
      .req_free_address   (req_free_address),
      .rsp_strobe         (rsp_strobe),
      .rsp_result_address (rsp_result_address),
      .rsp_status         (rsp_status),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   btha_reply_checker u_checker (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_opcode         (req_opcode),
      .req_request_bytes  (req_request_bytes),
      .req_free_address   (req_free_address),
      .rsp_strobe         (rsp_strobe),
      .rsp_result_address (rsp_result_address),
      .rsp_status         (rsp_status),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .mismatches         (mismatches),
      .pending            (pending)
   );

   always #2 clock = ~clock;

   // Learns which allocations succeeded so later frees can hand them back.
   always @(posedge clock) begin : track_live
      logic op;
      if (reset) begin
         issued_ops.delete();
      end else begin
         if (start && !busy)
            issued_ops.push_back(req_opcode);
         if (rsp_strobe && issued_ops.size() > 0) begin
            op = issued_ops.pop_front();
            if (op == OP_ALLOC && rsp_status == ST_DONE)
               live_addrs.push_back(rsp_result_address);
            case (rsp_status)
               ST_DONE:    replies_done++;
               ST_NOROOM:  replies_noroom++;
               ST_INVALID: replies_invalid++;
               default:    ;
            endcase
         end
      end
   end

   // Presents one request beat and returns at the edge that accepts it.
   task automatic send_beat(input logic op, input logic [31:0] bytes,
                            input logic [31:0] addr);
      start             <= 1'b1;
      req_opcode        <= op;
      req_request_bytes <= bytes;
      req_free_address  <= addr;
      do @(posedge clock); while (busy);
      if (op == OP_ALLOC)
         allocs_sent++;
      else
         frees_sent++;
   endtask

   // Holds off new requests until every owed reply has arrived.
   task automatic wait_quiet();
      start <= 1'b0;
      @(posedge clock);
      while (pending != 0)
         @(posedge clock);
   endtask

   // Returns every outstanding allocation, including ones still in flight.
   task automatic release_all();
      wait_quiet();
      while (live_addrs.size() > 0) begin
         while (live_addrs.size() > 0)
            send_beat(OP_FREE, $urandom, live_addrs.pop_front());
         wait_quiet();
      end
   endtask

   // Both registers are written back to back; the block is idle here.
   task automatic write_heap_regs(input logic [31:0] base, input logic [10:0] count);
      csr_we    <= 1'b1;
      csr_index <= CSR_HEAP_BASE;
      csr_data  <= base;
      @(posedge clock);
      csr_index <= CSR_BLOCKS_IN_USE;
      csr_data  <= {21'd0, count};
      @(posedge clock);
      csr_we    <= 1'b0;
      cur_base  = base;
      cur_count = int'(count);
      settings++;
   endtask

   // One random request: mostly matched allocate and free traffic, some noise.
   task automatic random_beat();
      int           n;
      int           pick;
      int           idx;
      int           limit;
      int           blocks;
      logic [31:0]  bytes;
      logic [31:0]  addr;
      n     = (cur_count > TABLE_BLOCKS) ? TABLE_BLOCKS : cur_count;
      pick  = $urandom_range(0, 99);
      bytes = $urandom;
      addr  = $urandom;
      if (live_addrs.size() == 0 && pick < 40)
         pick = 60;
      if (pick < 40) begin
         // Hand back a live allocation, sometimes by an address inside its head block.
         idx  = $urandom_range(0, live_addrs.size() - 1);
         addr = live_addrs[idx];
         live_addrs.delete(idx);
         if ($urandom_range(0, 3) == 0)
            addr = addr + $urandom_range(1, BLOCK_BYTES - 1);
         send_beat(OP_FREE, bytes, addr);
      end else if (pick < 50) begin
         // Free at an arbitrary spot: free entries, mid-run, just past the end, anywhere.
         if ($urandom_range(0, 1) == 1)
            addr = cur_base + $urandom_range(0, n + 1) * BLOCK_BYTES
                   + $urandom_range(0, BLOCK_BYTES - 1);
         send_beat(OP_FREE, bytes, addr);
      end else if (pick < 92) begin
         limit  = (n >= 16) ? n / 8 : 2;
         blocks = $urandom_range(1, limit);
         bytes  = (blocks - 1) * BLOCK_BYTES + $urandom_range(1, BLOCK_BYTES);
         send_beat(OP_ALLOC, bytes, addr);
      end else begin
         // Edge sizes: zero, arbitrary, the whole heap, one byte over.
         case ($urandom_range(0, 3))
            0:       bytes = '0;
            1:       bytes = $urandom;
            2:       bytes = n * BLOCK_BYTES;
            default: bytes = n * BLOCK_BYTES + 1;
         endcase
         send_beat(OP_ALLOC, bytes, addr);
      end
   endtask

   // Random beats in bursts, with idle gaps between bursts that are sometimes none.
   task automatic run_random(input int beats);
      int left;
      int burst;
      int gap;
      left = beats;
      while (left > 0) begin
         burst = $urandom_range(1, 10);
         while (burst > 0 && left > 0) begin
            random_beat();
            burst--;
            left--;
         end
         case ($urandom_range(0, 5))
            0, 1:    gap = 0;
            2, 3:    gap = $urandom_range(1, 6);
            4:       gap = $urandom_range(7, 60);
            default: gap = $urandom_range(61, 900);
         endcase
         if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic heap_phase(input logic [31:0] base, input logic [10:0] count,
                             input int beats);
      release_all();
      write_heap_regs(base, count);
      run_random(beats);
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      while (busy)
         @(posedge clock);

      // Directed beats on a fresh table of 1024 blocks based at zero.
      write_heap_regs(32'h0, 11'd1024);
      send_beat(OP_ALLOC, 32'd0, $urandom);              // zero size
      send_beat(OP_ALLOC, 32'd1, $urandom);              // block 0
      send_beat(OP_ALLOC, 32'd4096, $urandom);           // block 1
      send_beat(OP_ALLOC, 32'd4097, $urandom);           // blocks 2 and 3
      send_beat(OP_ALLOC, 32'hFFFF_FFFF, $urandom);      // far too large
      send_beat(OP_ALLOC, 32'h0040_0000, $urandom);      // whole heap, no room
      send_beat(OP_ALLOC, 32'h0040_0001, $urandom);      // one block over
      send_beat(OP_FREE, $urandom, 32'h0000_1000);
      send_beat(OP_ALLOC, 32'd4096, $urandom);           // reuses block 1
      send_beat(OP_FREE, $urandom, 32'h0000_2005);       // unaligned head address
      send_beat(OP_ALLOC, 32'd12288, $urandom);          // blocks 2 to 4
      send_beat(OP_FREE, $urandom, 32'h0000_3000);       // middle of a run
      send_beat(OP_FREE, $urandom, 32'h0000_3000);       // already free entry
      send_beat(OP_ALLOC, 32'd8192, $urandom);
      send_beat(OP_FREE, $urandom, 32'h0040_0000);       // just past the table
      send_beat(OP_FREE, $urandom, 32'hFFFF_FFFF);
      send_beat(OP_FREE, $urandom, 32'h003F_F000);       // last entry, free
      send_beat(OP_ALLOC, 32'd1020 * 4096, $urandom);    // tail run one short
      send_beat(OP_ALLOC, 32'd1019 * 4096, $urandom);    // fills to the end
      send_beat(OP_ALLOC, 32'd1, $urandom);              // table full
      send_beat(OP_FREE, $urandom, 32'h0000_5000);       // long chain walk
      send_beat(OP_FREE, $urandom, 32'h0000_0000);

      // Random traffic across a spread of heap settings.
      heap_phase(32'hFFFF_F000, 11'd8, 70);
      heap_phase($urandom & 32'hFFFF_F000, 11'd64, 150);
      heap_phase(32'hFFFF_FFFF, 11'd1, 20);
      release_all();
      write_heap_regs(32'h0, 11'd0);
      send_beat(OP_ALLOC, 32'd1, $urandom);
      send_beat(OP_FREE, $urandom, 32'h0);
      run_random(10);
      heap_phase($urandom, 11'd2047, 60);
      heap_phase($urandom & 32'hFFFF_F000, 11'($urandom_range(2, 200)), 200);
      heap_phase(32'h0, 11'd1024, 50);

      // Let any late reply beat show up before the verdict.
      wait_quiet();
      repeat (2100) @(posedge clock);

      $display("Summary: %0d requests (%0d allocate, %0d free) over %0d heap settings.",
               allocs_sent + frees_sent, allocs_sent, frees_sent, settings);
      $display("Summary: %0d replies done, %0d without room, %0d rejected as invalid.",
               replies_done, replies_noroom, replies_invalid);
      if (mismatches == 0 && pending == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

   // Hard stop well beyond the slowest legal run.
   initial begin
      #40_000_000;
      $display("status: fail");
      $finish;
   end

endmodule

>>> sim.f
src/btha_pkg.sv
src/block_table_heap_allocator.sv
src/btha_checker.sv
bench/btha_reply_checker.sv
bench/block_table_heap_allocator_tb.sv
